FILE: design/gfmi_pkg.sv
// Shared types, microcode table and GF(2^128) helper functions of the multiply/invert unit.
package gfmi_pkg;

  localparam int unsigned FIELD_W    = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned DIGIT_W    = 32;
  localparam int unsigned NUM_DIGITS = FIELD_W / DIGIT_W;
  localparam int unsigned DIG_W      = $clog2(NUM_DIGITS);
  localparam int unsigned PC_W       = 5;
  localparam int unsigned CNT_W      = 6;

  // Program entry points and the last valid step.
  localparam logic [PC_W-1:0] PC_MUL  = 5'd0;
  localparam logic [PC_W-1:0] PC_INV  = 5'd2;
  localparam logic [PC_W-1:0] PC_LAST = 5'd27;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef enum logic [2:0] {
    OP_SQR  = 3'b001,
    OP_MUL  = 3'b010,
    OP_DONE = 3'b100
  } op_e;

  typedef enum logic {
    SEL_Y = 1'b0,
    SEL_A = 1'b1
  } sel_e;

  typedef struct packed {
    op_e              op;
    sel_e             sel;
    logic             save;
    logic [CNT_W-1:0] rep;
  } ctrl_t;

  function automatic ctrl_t uc(op_e op, sel_e sel, logic save, logic [CNT_W-1:0] rep);
    ctrl_t c;
    c.op   = op;
    c.sel  = sel;
    c.save = save;
    c.rep  = rep;
    return c;
  endfunction

  // Microcode ROM. Multiply: one product then done. Inverse: addition chain
  // 1,2,3,6,7,14,15,30,31,62,63,126,127 for a^(2^127-1), then one squaring.
  // rep holds the number of squarings minus one.
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      5'd0:    c = uc(OP_MUL,  SEL_Y, 1'b0, 6'd0);
      5'd1:    c = uc(OP_DONE, SEL_Y, 1'b0, 6'd0);
      5'd2:    c = uc(OP_SQR,  SEL_A, 1'b0, 6'd0);
      5'd3:    c = uc(OP_MUL,  SEL_A, 1'b0, 6'd0);
      5'd4:    c = uc(OP_SQR,  SEL_A, 1'b0, 6'd0);
      5'd5:    c = uc(OP_MUL,  SEL_A, 1'b0, 6'd0);
      5'd6:    c = uc(OP_SQR,  SEL_Y, 1'b1, 6'd2);
      5'd7:    c = uc(OP_MUL,  SEL_Y, 1'b0, 6'd0);
      5'd8:    c = uc(OP_SQR,  SEL_A, 1'b0, 6'd0);
      5'd9:    c = uc(OP_MUL,  SEL_A, 1'b0, 6'd0);
      5'd10:   c = uc(OP_SQR,  SEL_Y, 1'b1, 6'd6);
      5'd11:   c = uc(OP_MUL,  SEL_Y, 1'b0, 6'd0);
      5'd12:   c = uc(OP_SQR,  SEL_A, 1'b0, 6'd0);
      5'd13:   c = uc(OP_MUL,  SEL_A, 1'b0, 6'd0);
      5'd14:   c = uc(OP_SQR,  SEL_Y, 1'b1, 6'd14);
      5'd15:   c = uc(OP_MUL,  SEL_Y, 1'b0, 6'd0);
      5'd16:   c = uc(OP_SQR,  SEL_A, 1'b0, 6'd0);
      5'd17:   c = uc(OP_MUL,  SEL_A, 1'b0, 6'd0);
      5'd18:   c = uc(OP_SQR,  SEL_Y, 1'b1, 6'd30);
      5'd19:   c = uc(OP_MUL,  SEL_Y, 1'b0, 6'd0);
      5'd20:   c = uc(OP_SQR,  SEL_A, 1'b0, 6'd0);
      5'd21:   c = uc(OP_MUL,  SEL_A, 1'b0, 6'd0);
      5'd22:   c = uc(OP_SQR,  SEL_Y, 1'b1, 6'd62);
      5'd23:   c = uc(OP_MUL,  SEL_Y, 1'b0, 6'd0);
      5'd24:   c = uc(OP_SQR,  SEL_A, 1'b0, 6'd0);
      5'd25:   c = uc(OP_MUL,  SEL_A, 1'b0, 6'd0);
      5'd26:   c = uc(OP_SQR,  SEL_A, 1'b0, 6'd0);
      default: c = uc(OP_DONE, SEL_Y, 1'b0, 6'd0);
    endcase
    return c;
  endfunction

  // Reduce a 256-bit carry-less product modulo x^128 + x^7 + x^2 + x + 1.
  function automatic logic [FIELD_W-1:0] reduce256(logic [2*FIELD_W-1:0] w);
    logic [FIELD_W-1:0] h;
    logic [FIELD_W+6:0] t;
    logic [6:0]         ov;
    logic [FIELD_W-1:0] r;
    h  = w[2*FIELD_W-1:FIELD_W];
    t  = {7'b0, w[FIELD_W-1:0]} ^ {7'b0, h} ^ {6'b0, h, 1'b0}
       ^ {5'b0, h, 2'b0} ^ {h, 7'b0};
    ov = t[FIELD_W+6:FIELD_W];
    r  = t[FIELD_W-1:0] ^ {121'b0, ov} ^ {120'b0, ov, 1'b0}
       ^ {119'b0, ov, 2'b0} ^ {114'b0, ov, 7'b0};
    return r;
  endfunction

  // Square: spread coefficients to even positions, then reduce.
  function automatic logic [FIELD_W-1:0] gf_sqr(logic [FIELD_W-1:0] x);
    logic [2*FIELD_W-1:0] w;
    w = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      w[2*i] = x[i];
    end
    return reduce256(w);
  endfunction

  // One digit of a 32 x 128 carry-less product.
  function automatic logic [FIELD_W+DIGIT_W-1:0] clmul_digit(logic [DIGIT_W-1:0] d,
                                                             logic [FIELD_W-1:0] m);
    logic [FIELD_W+DIGIT_W-1:0] p;
    p = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (d[i]) begin
        p ^= ({{DIGIT_W{1'b0}}, m} << i);
      end
    end
    return p;
  endfunction

  // Fold the top digit of a 160-bit value back below x^128.
  function automatic logic [FIELD_W-1:0] fold_digit(logic [FIELD_W+DIGIT_W-1:0] t);
    logic [DIGIT_W-1:0] h;
    logic [FIELD_W-1:0] r;
    h = t[FIELD_W+DIGIT_W-1:FIELD_W];
    r = t[FIELD_W-1:0] ^ {96'b0, h} ^ {95'b0, h, 1'b0}
      ^ {94'b0, h, 2'b0} ^ {89'b0, h, 7'b0};
    return r;
  endfunction

endpackage

FILE: design/gf128_multiply_invert.sv
// GF(2^128) multiply and invert unit driven by a microcoded sequencer.
// Multiply: 4 digit steps of the 32 x 128 multiplier, then done.
// Invert: 127 squarings and 12 products of 4 digit steps each, then done.
// One transaction at a time; the next is accepted once the result is in the output register.
// A waiting result sits in the output register while the next transaction is accepted.
// rst_ni (asynchronous, active low) clears the sequencer and output valid; data is not reset.
module gf128_multiply_invert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [63:0] a_low_i,
  input  logic [63:0] a_high_i,
  input  logic [63:0] b_low_i,
  input  logic [63:0] b_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o
);

  localparam int unsigned FW = gfmi_pkg::FIELD_W;
  localparam int unsigned DW = gfmi_pkg::DIGIT_W;

  // Sequencer control state.
  gfmi_pkg::state_e                 state_q, state_d;
  logic [gfmi_pkg::PC_W-1:0]        pc_q, pc_d;
  logic [gfmi_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [gfmi_pkg::DIG_W-1:0]       dig_q, dig_d;
  logic                             out_valid_q, out_valid_d;

  // Datapath registers: working value, saved chain value, operand, product accumulator, result.
  logic [FW-1:0] x_q, x_d;
  logic [FW-1:0] y_q, y_d;
  logic [FW-1:0] a_q, a_d;
  logic [FW-1:0] acc_q, acc_d;
  logic [FW-1:0] res_q, res_d;

  gfmi_pkg::ctrl_t ctrl;
  logic            in_accept;
  logic            out_free;
  logic [FW-1:0]   mul_op;
  logic [DW-1:0]   digit;
  logic [FW-1:0]   acc_in;
  logic [FW-1:0]   mul_next;

  assign ctrl       = gfmi_pkg::ucode(pc_q);
  assign in_stall_o = (state_q != gfmi_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Multiplier digit step, most significant digit of x first (Horner form):
  // acc <- acc * x^32 + digit * m, then fold the spilled digit back.
  assign mul_op   = (ctrl.sel == gfmi_pkg::SEL_A) ? a_q : y_q;
  assign digit    = x_q[DW*(gfmi_pkg::NUM_DIGITS-1-int'(dig_q)) +: DW];
  assign acc_in   = (dig_q == '0) ? '0 : acc_q;
  assign mul_next = gfmi_pkg::fold_digit({acc_in, {DW{1'b0}}}
                                         ^ gfmi_pkg::clmul_digit(digit, mul_op));

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q;
    x_d         = x_q;
    y_d         = y_q;
    a_d         = a_q;
    acc_d       = acc_q;
    res_d       = res_q;

    // Drop the result once the consumer takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      gfmi_pkg::ST_IDLE: begin
        if (in_accept) begin
          x_d     = {a_high_i, a_low_i};
          a_d     = {a_high_i, a_low_i};
          y_d     = {b_high_i, b_low_i};
          pc_d    = action_i ? gfmi_pkg::PC_INV : gfmi_pkg::PC_MUL;
          cnt_d   = '0;
          dig_d   = '0;
          state_d = gfmi_pkg::ST_RUN;
        end
      end
      gfmi_pkg::ST_RUN: begin
        case (ctrl.op)
          gfmi_pkg::OP_SQR: begin
            // Save the pre-square value on the first pass when the step asks for it.
            if (ctrl.save && (cnt_q == '0)) begin
              y_d = x_q;
            end
            x_d = gfmi_pkg::gf_sqr(x_q);
            // Repeat in place until the count is reached, then advance.
            if (cnt_q == ctrl.rep) begin
              cnt_d = '0;
              pc_d  = pc_q + gfmi_pkg::PC_W'(1);
            end else begin
              cnt_d = cnt_q + gfmi_pkg::CNT_W'(1);
            end
          end
          gfmi_pkg::OP_MUL: begin
            acc_d = mul_next;
            if (dig_q == gfmi_pkg::DIG_W'(gfmi_pkg::NUM_DIGITS - 1)) begin
              x_d   = mul_next;
              dig_d = '0;
              pc_d  = pc_q + gfmi_pkg::PC_W'(1);
            end else begin
              dig_d = dig_q + gfmi_pkg::DIG_W'(1);
            end
          end
          gfmi_pkg::OP_DONE: begin
            // Hold until the output register is free or drains this cycle.
            if (out_free) begin
              res_d       = x_q;
              out_valid_d = 1'b1;
              state_d     = gfmi_pkg::ST_IDLE;
            end
          end
          default: begin
            state_d = gfmi_pkg::ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = gfmi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfmi_pkg::ST_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    a_q   <= a_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_low_o  = res_q[gfmi_pkg::HALF_W-1:0];
  assign result_high_o = res_q[FW-1:gfmi_pkg::HALF_W];

  // The program counter never runs past the last microcode step.
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gfmi_pkg::ST_RUN) |-> (pc_q <= gfmi_pkg::PC_LAST))
    else $error("sequencer ran past the end of the program");

  // The repeat counter is only in use during squaring steps.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gfmi_pkg::ST_RUN && ctrl.op != gfmi_pkg::OP_SQR) |-> (cnt_q == '0))
    else $error("repeat counter left nonzero outside a squaring step");

  // The digit counter is only in use during multiply steps.
  a_dig_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gfmi_pkg::ST_RUN && ctrl.op != gfmi_pkg::OP_MUL) |-> (dig_q == '0))
    else $error("digit counter left nonzero outside a multiply step");

  // A completing program presents its result and frees the input next cycle.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gfmi_pkg::ST_RUN && ctrl.op == gfmi_pkg::OP_DONE && out_free)
    |=> (out_valid_q && state_q == gfmi_pkg::ST_IDLE))
    else $error("result not presented at end of program");

endmodule

FILE: test/gf128_multiply_invert_test.sv
// Self-checking testbench for the GF(2^128) multiply and invert unit.
module gf128_multiply_invert_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes carried by the one-bit action field.
  localparam logic ACT_MULTIPLY = 1'b0;
  localparam logic ACT_INVERT   = 1'b1;

  // x^128 folds back as x^7 + x^2 + x + 1.
  localparam logic [127:0] POLY_TAIL = 128'h87;
  localparam logic [127:0] FIELD_ONE = 128'h1;
  localparam logic [127:0] ALL_ONES  = {128{1'b1}};

  localparam int SETTLE_CYCLES = 400;   // longer than one inversion
  localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
  localparam int REPORT_LIMIT  = 10;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_BURSTY,
    DRAIN_HEAVY
  } drain_mode_e;

  typedef struct {
    logic        action;
    logic [63:0] low;
    logic [63:0] high;
  } field_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        action_i      = ACT_MULTIPLY;
  logic [63:0] a_low_i       = '0;
  logic [63:0] a_high_i      = '0;
  logic [63:0] b_low_i       = '0;
  logic [63:0] b_high_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [63:0] result_low_o;
  logic [63:0] result_high_o;

  // Results predicted for accepted transactions, oldest first.
  field_result_t pending_results[$];

  int          failures      = 0;
  bit          sender_gaps   = 1'b0;
  int          burst_left    = 0;
  drain_mode_e drain_mode    = DRAIN_FREE;
  bit          hold_request  = 1'b0;

  gf128_multiply_invert DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .a_low_i      (a_low_i),
    .a_high_i     (a_high_i),
    .b_low_i      (b_low_i),
    .b_high_i     (b_high_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_low_o (result_low_o),
    .result_high_o(result_high_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Field arithmetic used for prediction
  // ---------------------------------------------------------------------------

  // Multiply with interleaved reduction: walk y from its top coefficient down,
  // shift the running sum by x, fold any x^128 term, add x where y has a one.
  function automatic logic [127:0] field_mul(logic [127:0] x, logic [127:0] y);
    logic [127:0] acc;
    logic         spill;
    acc = '0;
    for (int i = 127; i >= 0; i--) begin
      spill = acc[127];
      acc   = acc << 1;
      if (spill) acc ^= POLY_TAIL;
      if (y[i])  acc ^= x;
    end
    return acc;
  endfunction

  // a^(2^128-2): 127 rounds of multiply and square, right to left over the
  // exponent bits, then one final squaring. Zero maps to zero on its own.
  function automatic logic [127:0] field_inverse(logic [127:0] x);
    logic [127:0] acc;
    logic [127:0] power;
    acc   = FIELD_ONE;
    power = x;
    for (int i = 0; i < 127; i++) begin
      acc   = field_mul(acc, power);
      power = field_mul(power, power);
    end
    return field_mul(acc, acc);
  endfunction

  // Operand with a bias toward edge shapes: zero, all ones, single terms, all ones
  // but one term, low-degree values, one empty half; the rest is uniform.
  function automatic logic [127:0] random_operand();
    logic [127:0] v;
    case ($urandom_range(0, 11))
      0:       v = '0;
      1:       v = ALL_ONES;
      2:       v = FIELD_ONE << $urandom_range(0, 127);
      3:       v = ~(FIELD_ONE << $urandom_range(0, 127));
      4:       v = 128'($urandom_range(0, 255));
      5:       v = {$urandom, $urandom, 64'h0};
      6:       v = {64'h0, $urandom, $urandom};
      default: v = {$urandom, $urandom, $urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic void note_failure(string what);
    if (failures < REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
    failures++;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: present one transaction, hold it until accepted, then maybe idle
  // ---------------------------------------------------------------------------

  task automatic send_item(logic action, logic [127:0] a, logic [127:0] b);
    field_result_t want;
    want.action = action;
    {want.high, want.low} = (action == ACT_INVERT) ? field_inverse(a) : field_mul(a, b);
    in_valid_i <= 1'b1;
    action_i   <= action;
    a_low_i    <= a[63:0];
    a_high_i   <= a[127:64];
    b_low_i    <= b[63:0];
    b_high_i   <= b[127:64];
    // Hold the payload until an edge sees valid high and stall low.
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(want);
    // Work in bursts; drop valid only when a gap starts so it is never
    // lowered and raised again in the same step.
    if (sender_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  // Pause the sender until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic run_random_items(int count, int invert_pct);
    logic action;
    for (int n = 0; n < count; n++) begin
      action = ($urandom_range(0, 99) < invert_pct) ? ACT_INVERT : ACT_MULTIPLY;
      send_item(action, random_operand(), random_operand());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on its own pattern; a hold request freezes it for a long
  // stretch counted here
  // ---------------------------------------------------------------------------

  initial begin : drain_side
    int phase;
    int period;
    phase  = 0;
    period = 4;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        case (drain_mode)
          DRAIN_FREE:   out_stall_i <= 1'b0;
          DRAIN_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 30);
          DRAIN_HEAVY:  out_stall_i <= ($urandom_range(0, 99) < 75);
          DRAIN_BURSTY: begin
            // Stall for the first half of a window of random length.
            phase++;
            if (phase >= period) begin
              phase  = 0;
              period = $urandom_range(2, 12);
            end
            out_stall_i <= (phase < period / 2);
          end
          default:      out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_result
    field_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result high %h low %h",
                               result_high_o, result_low_o));
      end else begin
        want = pending_results.pop_front();
        if (result_low_o !== want.low) begin
          note_failure($sformatf("result_low mismatch (action %0d): expected %h got %h",
                                 want.action, want.low, result_low_o));
        end
        if (result_high_o !== want.high) begin
          note_failure($sformatf("result_high mismatch (action %0d): expected %h got %h",
                                 want.action, want.high, result_high_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Products at the edges: zero, one, all ones, terms that cross the halves
  // and terms whose product needs the second folding pass.
  task automatic test_directed_multiply();
    sender_gaps = 1'b0;
    drain_mode  = DRAIN_FREE;
    send_item(ACT_MULTIPLY, '0, random_operand());
    send_item(ACT_MULTIPLY, FIELD_ONE, ALL_ONES);
    send_item(ACT_MULTIPLY, ALL_ONES, ALL_ONES);
    send_item(ACT_MULTIPLY, FIELD_ONE << 127, FIELD_ONE << 1);
    send_item(ACT_MULTIPLY, FIELD_ONE << 127, FIELD_ONE << 127);
    send_item(ACT_MULTIPLY, FIELD_ONE << 64, FIELD_ONE << 64);
    send_item(ACT_MULTIPLY, FIELD_ONE << 63, FIELD_ONE << 1);
    send_item(ACT_MULTIPLY, {$urandom, $urandom, $urandom, $urandom}, FIELD_ONE);
    send_item(ACT_MULTIPLY, {ALL_ONES[63:0], 64'h0}, {64'h0, ALL_ONES[63:0]});
    wait_drained();
  endtask

  // Inversions: zero (with and without b set, b must not matter), one, x,
  // the top term, all ones, each half alone and the modulus tail.
  task automatic test_directed_invert();
    sender_gaps = 1'b0;
    drain_mode  = DRAIN_FREE;
    send_item(ACT_INVERT, '0, '0);
    send_item(ACT_INVERT, '0, ALL_ONES);
    send_item(ACT_INVERT, FIELD_ONE, random_operand());
    send_item(ACT_INVERT, FIELD_ONE << 1, '0);
    send_item(ACT_INVERT, FIELD_ONE << 127, ALL_ONES);
    send_item(ACT_INVERT, ALL_ONES, '0);
    send_item(ACT_INVERT, {64'h0, ALL_ONES[63:0]}, '0);
    send_item(ACT_INVERT, {ALL_ONES[63:0], 64'h0}, '0);
    send_item(ACT_INVERT, POLY_TAIL, FIELD_ONE);
    send_item(ACT_INVERT, {$urandom, $urandom, $urandom, $urandom},
              {$urandom, $urandom, $urandom, $urandom});
    wait_drained();
  endtask

  // Bulk mix with both sides idling at random.
  task automatic test_random_mixed();
    sender_gaps = 1'b1;
    drain_mode  = DRAIN_RANDOM;
    run_random_items(700, 35);
    wait_drained();
  endtask

  // No idling anywhere: transactions back to back at the block's own rate.
  task automatic test_back_to_back();
    sender_gaps = 1'b0;
    drain_mode  = DRAIN_FREE;
    run_random_items(200, 50);
    wait_drained();
  endtask

  // Receiver stalls in windows while the sender works in bursts.
  task automatic test_bursty_drain();
    sender_gaps = 1'b1;
    drain_mode  = DRAIN_BURSTY;
    run_random_items(250, 35);
    wait_drained();
  endtask

  // Receiver mostly stalled, sender always offering: results wait in the
  // output register while the next transaction runs.
  task automatic test_heavy_stall();
    sender_gaps = 1'b0;
    drain_mode  = DRAIN_HEAVY;
    run_random_items(200, 20);
    wait_drained();
  endtask

  // Freeze the receiver for a long stretch and keep offering, so the block
  // fills and stalls its input; then let everything drain.
  task automatic test_long_holdoff();
    sender_gaps  = 1'b0;
    drain_mode   = DRAIN_FREE;
    hold_request = 1'b1;
    run_random_items(8, 25);
    wait_drained();
  endtask

  initial begin : main
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_multiply();
    test_directed_invert();
    test_random_mixed();
    test_back_to_back();
    test_bursty_drain();
    test_heavy_stall();
    test_long_holdoff();

    // Let any stray result show up before the verdict.
    drain_mode = DRAIN_FREE;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    end

    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
